// File: design/bsia_pkg.sv
// Shared types, codes and command/status bundles for the bounded stack.
package bsia_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int IDX_W  = 3;

  // Operation codes; codes five to seven are ignored.
  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_POP     = 3'd1;
  localparam logic [OP_W-1:0] OP_UPDATE  = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd3;
  localparam logic [OP_W-1:0] OP_DISPLAY = 3'd4;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_TOP    = 2'd0,
    RD_IDX    = 2'd1,
    RD_BOTTOM = 2'd2,
    RD_PTR    = 2'd3
  } rd_sel_t;

  typedef enum logic {
    WR_TOP = 1'b0,
    WR_IDX = 1'b1
  } wr_sel_t;

  typedef enum logic {
    RES_ZERO = 1'b0,
    RES_MEM  = 1'b1
  } res_src_t;

  // Controller to datapath.
  typedef struct packed {
    logic     wr_en;
    wr_sel_t  wr_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     ptr_load;
    logic     ptr_inc;
    logic     res_load;
    res_src_t res_src;
    status_t  res_status;
    logic     res_last;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_ok;
    logic ptr_end;
    logic out_free;
  } sts_t;

endpackage

// File: design/bsia_if.sv
// Valid/ready channel interfaces for stack requests and results.
interface bsia_in_if;
  logic                            valid;
  logic                            ready;
  logic [bsia_pkg::OP_W-1:0]       op;
  logic [bsia_pkg::IDX_W-1:0]      index;
  logic signed [bsia_pkg::DATA_W-1:0] value;

  modport source (output valid, op, index, value, input ready);
  modport sink   (input valid, op, index, value, output ready);
endinterface

interface bsia_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bsia_pkg::DATA_W-1:0] data;
  logic [1:0]                         status;
  logic                               last;

  modport source (output valid, data, status, last, input ready);
  modport sink   (input valid, data, status, last, output ready);
endinterface

// File: design/bsia_dp.sv
// Stack datapath: entry memory, fill count, display pointer and result register.
module bsia_dp #(
  parameter int DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bsia_pkg::cmd_t                     cmd,
  output bsia_pkg::sts_t                     sts,
  input  logic [bsia_pkg::IDX_W-1:0]         index,
  input  logic signed [bsia_pkg::DATA_W-1:0] value,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [bsia_pkg::DATA_W-1:0] out_data,
  output logic [1:0]                         out_status,
  output logic                               out_last
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > bsia_pkg::IDX_W) ? CW : bsia_pkg::IDX_W;

  logic signed [bsia_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [bsia_pkg::DATA_W-1:0] rd_data;
  logic [CW-1:0]                      cnt;
  logic [CW-1:0]                      ptr;
  logic [AW-1:0]                      wr_addr;
  logic [AW-1:0]                      rd_addr;

  assign sts.full     = (cnt == CW'(DEPTH));
  assign sts.empty    = (cnt == '0);
  assign sts.idx_ok   = (CMPW'(index) < CMPW'(cnt));
  assign sts.ptr_end  = (ptr == cnt);
  assign sts.out_free = !out_valid || out_ready;

  assign wr_addr = (cmd.wr_sel == bsia_pkg::WR_IDX) ? AW'(index) : AW'(cnt);

  always_comb begin
    unique case (cmd.rd_sel)
      bsia_pkg::RD_TOP:    rd_addr = AW'(cnt - CW'(1));
      bsia_pkg::RD_IDX:    rd_addr = AW'(index);
      bsia_pkg::RD_BOTTOM: rd_addr = '0;
      default:             rd_addr = AW'(ptr);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= value;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ptr <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.ptr_load) begin
        ptr <= CW'(1);
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + CW'(1);
      end
    end
  end

  // Result register: load a new beat, or drop the current one once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data   <= (cmd.res_src == bsia_pkg::RES_MEM) ? rd_data : '0;
      out_status <= cmd.res_status;
      out_last   <= cmd.res_last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH)) else $error("fill count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en && cmd.wr_sel == bsia_pkg::WR_TOP |-> !sts.full && cmd.cnt_inc)
    else $error("push write without room");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en && cmd.rd_sel == bsia_pkg::RD_PTR |-> ptr < cnt)
    else $error("display read beyond top");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> sts.out_free) else $error("pending result overwritten");

endmodule

// File: design/bsia_ctrl.sv
// Stack controller: decodes operations and sequences reads and display beats.
module bsia_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [bsia_pkg::OP_W-1:0]     op,
  output logic                          in_ready,
  input  bsia_pkg::sts_t                sts,
  output bsia_pkg::cmd_t                cmd
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   disp;
  logic   disp_next;
  logic   acc;

  assign in_ready = (state == S_IDLE) && sts.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    disp_next      = disp;
    cmd            = '0;
    cmd.res_last   = 1'b1;
    cmd.res_status = bsia_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (op)
            bsia_pkg::OP_PUSH: begin
              cmd.res_load = 1'b1;
              if (sts.full) begin
                cmd.res_status = bsia_pkg::ST_FULL;
              end else begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = bsia_pkg::WR_TOP;
                cmd.cnt_inc = 1'b1;
              end
            end
            bsia_pkg::OP_POP: begin
              if (sts.empty) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = bsia_pkg::ST_EMPTY;
              end else begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = bsia_pkg::RD_TOP;
                cmd.cnt_dec = 1'b1;
                disp_next   = 1'b0;
                state_next  = S_FETCH;
              end
            end
            bsia_pkg::OP_UPDATE: begin
              cmd.res_load = 1'b1;
              if (sts.idx_ok) begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bsia_pkg::WR_IDX;
              end else begin
                cmd.res_status = bsia_pkg::ST_BADIDX;
              end
            end
            bsia_pkg::OP_PEEK: begin
              if (sts.idx_ok) begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bsia_pkg::RD_IDX;
                disp_next  = 1'b0;
                state_next = S_FETCH;
              end else begin
                cmd.res_load   = 1'b1;
                cmd.res_status = bsia_pkg::ST_BADIDX;
              end
            end
            bsia_pkg::OP_DISPLAY: begin
              if (sts.empty) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = bsia_pkg::ST_EMPTY;
              end else begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = bsia_pkg::RD_BOTTOM;
                cmd.ptr_load = 1'b1;
                disp_next    = 1'b1;
                state_next   = S_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        // Hold the read word until the result register frees up.
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = bsia_pkg::RES_MEM;
          cmd.res_last = !disp || sts.ptr_end;
          if (disp && !sts.ptr_end) begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = bsia_pkg::RD_PTR;
            cmd.ptr_inc = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      disp  <= 1'b0;
    end else begin
      state <= state_next;
      disp  <= disp_next;
    end
  end

  a_fetch_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |=> state == S_FETCH) else $error("read issued without fetch");

  a_last_ends_fetch: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH && cmd.res_load && cmd.res_last |=> state == S_IDLE)
    else $error("final beat did not end the item");

endmodule

// File: design/bounded_stack_with_index_access_top.sv
// Top level of the bounded stack with push, pop, update, peek and display.
//
//   channel   dir  payload                         beat
//   in_ch     in   op[2:0] index[2:0] value[31:0]   one request
//   out_ch    out  data[31:0] status[1:0] last      one result
//
// Push, update and every error: the result loads as the request is taken.
// Pop and peek: one registered read of the entry memory, then the result loads.
// Display: one beat per stored entry, one per cycle while the result register is free, after a registered read;
// the single memory read port paces it.
// Reset (rst, synchronous) empties the stack; entries are not cleared.
// A stalled result holds its beat; requests wait until it is free or being taken.
module bounded_stack_with_index_access_top #(
  parameter int DEPTH = 8
) (
  input logic         clk,
  input logic         rst,
  bsia_in_if.sink     in_ch,
  bsia_out_if.source  out_ch
);

  bsia_pkg::cmd_t cmd;
  bsia_pkg::sts_t sts;

  // Sequence each request: decode, issue memory accesses, stream display beats.
  bsia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .op       (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the entries, the fill count and the result register.
  bsia_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .index      (in_ch.index),
    .value      (in_ch.value),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_data   (out_ch.data),
    .out_status (out_ch.status),
    .out_last   (out_ch.last)
  );

endmodule
